// ----- sv/cdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared types, codes, month table and the control program for the date
// counter sequencer.
// ----------------------------------------------------------------------------
package cdc_pkg;

    // Calendar limits. The year is kept as an offset from the base year.
    localparam logic [11:0] YEAR_BASE = 12'd1900;
    localparam logic [11:0] YEAR_TOP  = 12'd2100;
    localparam logic [7:0]  OFS_TOP   = 8'd200;
    localparam logic [3:0]  MONTH_TOP = 4'd12;
    localparam logic [4:0]  DAY_TOP   = 5'd31;
    localparam logic [4:0]  DAY_LEAP  = 5'd29;
    localparam logic [3:0]  MONTH_FEB = 4'd2;

    // Operation codes carried on the input channel.
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_SET = 2'd0;
    localparam t_mode MODE_INC = 2'd1;
    localparam t_mode MODE_ADD = 2'd2;

    // Status codes reported with each result.
    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_MONTH = 3'd1;
    localparam t_status ST_BAD_YEAR  = 3'd2;
    localparam t_status ST_BAD_DAY   = 3'd3;
    localparam t_status ST_OVERFLOW  = 3'd4;

    // Program counter and step addresses.
    typedef logic [2:0] t_pc;
    localparam t_pc PC_FETCH = 3'd0;
    localparam t_pc PC_SET   = 3'd1;
    localparam t_pc PC_INC   = 3'd2;
    localparam t_pc PC_ADD   = 3'd3;
    localparam t_pc PC_NOP   = 3'd4;
    localparam t_pc PC_EMIT  = 3'd5;
    localparam t_pc PC_SPARE = 3'd6;
    localparam t_pc PC_LAST  = 3'd7;

    // Datapath operations selected by the control word.
    typedef logic [2:0] t_op;
    localparam t_op OP_NONE   = 3'd0;
    localparam t_op OP_ACCEPT = 3'd1;
    localparam t_op OP_LOAD   = 3'd2;
    localparam t_op OP_INC    = 3'd3;
    localparam t_op OP_ADD    = 3'd4;
    localparam t_op OP_EMIT   = 3'd5;

    // Jump conditions. When the condition holds the sequencer jumps,
    // otherwise it repeats the current step.
    typedef logic [1:0] t_cond;
    localparam t_cond COND_ALWAYS   = 2'd0;
    localparam t_cond COND_IN_VALID = 2'd1;
    localparam t_cond COND_CNT_DONE = 2'd2;
    localparam t_cond COND_OUT_FREE = 2'd3;

    // One control word. With dispatch set, the jump target is offset by the mode.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  dispatch;
        t_pc   tgt;
    } t_uword;

    // Status flags that the datapath returns to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic cnt_done;
        logic out_free;
    } t_flags;

    // Control program.
    localparam t_uword UCODE [8] = '{
        '{OP_ACCEPT, COND_IN_VALID, 1'b1, PC_SET},   // fetch a beat, branch on mode
        '{OP_LOAD,   COND_ALWAYS,   1'b0, PC_EMIT},  // set date
        '{OP_INC,    COND_ALWAYS,   1'b0, PC_EMIT},  // one day forward
        '{OP_ADD,    COND_CNT_DONE, 1'b0, PC_EMIT},  // one day per pass until done
        '{OP_NONE,   COND_ALWAYS,   1'b0, PC_EMIT},  // unused mode
        '{OP_EMIT,   COND_OUT_FREE, 1'b0, PC_FETCH}, // hand result to output register
        '{OP_NONE,   COND_ALWAYS,   1'b0, PC_FETCH},
        '{OP_NONE,   COND_ALWAYS,   1'b0, PC_FETCH}
    };

    // Days per month in a common year; unused codes read as zero.
    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // Leap test on a year offset from 1900. Valid for offsets 0 to 200, where
    // only 1900 and 2100 are century years that are not leap years.
    function automatic logic ofs_leap(input logic [7:0] ofs);
        return (ofs[1:0] == 2'b00) && (ofs != 8'd0) && (ofs != OFS_TOP);
    endfunction

    // Length of a month, with February stretched in leap years.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = MONTH_LEN[month];
        if (month == MONTH_FEB && leap) begin
            len = DAY_LEAP;
        end
        return len;
    endfunction

endpackage

// ----- sv/cdc_if.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface cdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [11:0] new_year;
    logic [15:0] add_count;

    modport source (output valid, mode, new_day, new_month, new_year, add_count,
                    input ready);
    modport sink   (input valid, mode, new_day, new_month, new_year, add_count,
                    output ready);
endinterface

interface cdc_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic [2:0]  status;

    modport source (output valid, out_day, out_month, out_year, status, input ready);
    modport sink   (input valid, out_day, out_month, out_year, status, output ready);
endinterface

// ----- sv/cdc_seq.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module cdc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cdc_pkg::t_flags i_flags,
    input  cdc_pkg::t_mode  i_mode,
    output cdc_pkg::t_uword o_uword
);

    cdc_pkg::t_pc    r_pc;
    cdc_pkg::t_pc    n_pc;
    cdc_pkg::t_uword w_uword;
    logic            w_take;

    // Control word for the current step.
    assign w_uword = cdc_pkg::UCODE[r_pc];
    assign o_uword = w_uword;

    // Evaluate the jump condition.
    always_comb begin
        unique case (w_uword.cond)
            cdc_pkg::COND_ALWAYS:   w_take = 1'b1;
            cdc_pkg::COND_IN_VALID: w_take = i_flags.in_valid;
            cdc_pkg::COND_CNT_DONE: w_take = i_flags.cnt_done;
            cdc_pkg::COND_OUT_FREE: w_take = i_flags.out_free;
            default:                w_take = 1'b1;
        endcase
    end

    // Next step: jump, dispatch on mode, or repeat this step.
    always_comb begin
        n_pc = r_pc;
        if (w_take) begin
            if (w_uword.dispatch) begin
                n_pc = cdc_pkg::t_pc'(w_uword.tgt + {1'b0, i_mode});
            end else begin
                n_pc = w_uword.tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cdc_pkg::PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- sv/cdc_dp.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter datapath
// Date registers, day stepper, set validation, day counter and the output
// register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module cdc_dp #(
    parameter int ADD_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cdc_pkg::t_uword i_uword,
    input  logic            i_in_valid,
    input  logic [4:0]      i_new_day,
    input  logic [3:0]      i_new_month,
    input  logic [11:0]     i_new_year,
    input  logic [15:0]     i_add_count,
    input  logic            i_out_ready,
    output cdc_pkg::t_flags o_flags,
    output logic            o_out_valid,
    output logic [4:0]      o_out_day,
    output logic [3:0]      o_out_month,
    output logic [11:0]     o_out_year,
    output logic [2:0]      o_status
);

    // Stored date; the year is an offset from 1900.
    logic [4:0]            r_day,   n_day;
    logic [3:0]            r_month, n_month;
    logic [7:0]            r_ofs,   n_ofs;
    logic [ADD_BITS-1:0]   r_cnt,   n_cnt;
    cdc_pkg::t_status      r_stat,  n_stat;
    logic [4:0]            r_nday;
    logic [3:0]            r_nmonth;
    logic [11:0]           r_nyear;
    logic                  r_out_valid;
    logic [4:0]            r_out_day;
    logic [3:0]            r_out_month;
    logic [11:0]           r_out_year;
    cdc_pkg::t_status      r_out_stat;

    logic                  w_accept;
    logic                  w_emit;
    logic                  w_out_free;
    logic                  w_at_limit;
    logic [4:0]            w_dim;
    logic [4:0]            w_adv_day;
    logic [3:0]            w_adv_month;
    logic [7:0]            w_adv_ofs;
    logic [31:0]           w_cnt_ext;
    logic [11:0]           w_ydiff;
    logic [7:0]            w_nofs;
    logic                  w_bad_month;
    logic                  w_bad_year;
    logic                  w_bad_day;

    assign w_accept   = (i_uword.op == cdc_pkg::OP_ACCEPT) && i_in_valid;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (i_uword.op == cdc_pkg::OP_EMIT) && w_out_free;
    assign w_cnt_ext  = {16'd0, i_add_count};

    // Limit check and the date one day later.
    assign w_at_limit = (r_ofs == cdc_pkg::OFS_TOP) && (r_month == cdc_pkg::MONTH_TOP)
                     && (r_day == cdc_pkg::DAY_TOP);
    assign w_dim      = cdc_pkg::days_in(r_month, cdc_pkg::ofs_leap(r_ofs));

    always_comb begin
        w_adv_day   = 5'd1;
        w_adv_month = r_month;
        w_adv_ofs   = r_ofs;
        if (r_day < w_dim) begin
            w_adv_day = r_day + 5'd1;
        end else if (r_month < cdc_pkg::MONTH_TOP) begin
            w_adv_month = r_month + 4'd1;
        end else begin
            w_adv_month = 4'd1;
            w_adv_ofs   = r_ofs + 8'd1;
        end
    end

    // Set validation in priority order: month, year, day.
    assign w_ydiff     = r_nyear - cdc_pkg::YEAR_BASE;
    assign w_nofs      = w_ydiff[7:0];
    assign w_bad_month = (r_nmonth == 4'd0) || (r_nmonth > cdc_pkg::MONTH_TOP);
    assign w_bad_year  = (r_nyear < cdc_pkg::YEAR_BASE) || (r_nyear > cdc_pkg::YEAR_TOP);
    assign w_bad_day   = (r_nday == 5'd0)
                      || (r_nday > cdc_pkg::days_in(r_nmonth, cdc_pkg::ofs_leap(w_nofs)));

    // Flags back to the sequencer.
    assign o_flags.in_valid = i_in_valid;
    assign o_flags.cnt_done = (r_cnt == '0) || w_at_limit;
    assign o_flags.out_free = w_out_free;

    // Operation decode.
    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_ofs   = r_ofs;
        n_cnt   = r_cnt;
        n_stat  = r_stat;
        unique case (i_uword.op) inside
            cdc_pkg::OP_ACCEPT: begin
                if (w_accept) begin
                    n_cnt  = w_cnt_ext[ADD_BITS-1:0];
                    n_stat = cdc_pkg::ST_OK;
                end
            end
            cdc_pkg::OP_LOAD: begin
                if (w_bad_month) begin
                    n_stat = cdc_pkg::ST_BAD_MONTH;
                end else if (w_bad_year) begin
                    n_stat = cdc_pkg::ST_BAD_YEAR;
                end else if (w_bad_day) begin
                    n_stat = cdc_pkg::ST_BAD_DAY;
                end else begin
                    n_day   = r_nday;
                    n_month = r_nmonth;
                    n_ofs   = w_nofs;
                end
            end
            cdc_pkg::OP_INC: begin
                if (w_at_limit) begin
                    n_stat = cdc_pkg::ST_OVERFLOW;
                end else begin
                    n_day   = w_adv_day;
                    n_month = w_adv_month;
                    n_ofs   = w_adv_ofs;
                end
            end
            cdc_pkg::OP_ADD: begin
                if (r_cnt != '0) begin
                    if (w_at_limit) begin
                        n_stat = cdc_pkg::ST_OVERFLOW;
                    end else begin
                        n_day   = w_adv_day;
                        n_month = w_adv_month;
                        n_ofs   = w_adv_ofs;
                        n_cnt   = r_cnt - ADD_BITS'(1);
                    end
                end
            end
            cdc_pkg::OP_NONE, cdc_pkg::OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Date and output-valid control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_ofs       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_day   <= n_day;
            r_month <= n_month;
            r_ofs   <= n_ofs;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working payload: day count, status and the captured set fields.
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_stat <= n_stat;
        if (w_accept) begin
            r_nday   <= i_new_day;
            r_nmonth <= i_new_month;
            r_nyear  <= i_new_year;
        end
    end

    // Output register, loaded when the result is handed over.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_day   <= r_day;
            r_out_month <= r_month;
            r_out_year  <= cdc_pkg::YEAR_BASE + {4'd0, r_ofs};
            r_out_stat  <= r_stat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_day   = r_out_day;
    assign o_out_month = r_out_month;
    assign o_out_year  = r_out_year;
    assign o_status    = r_out_stat;

endmodule

// ----- sv/calendar_date_counter_core.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter core
// Gregorian date register (1 Jan 1900 to 31 Dec 2100) with set, one-day
// increment and add-days commands, run by a small control program.
// ----------------------------------------------------------------------------
// Usage:
// - i_in carries one command beat: mode 0 sets the date from new_day,
//   new_month and new_year after checking month, year and day in turn;
//   mode 1 moves one day forward; mode 2 moves add_count days forward.
// - o_out returns exactly one result beat per command: the date after the
//   command and a status (ok, bad month, bad year, bad day, overflow).
// - Commands are taken one at a time. Set, increment and the unused mode
//   pass through their work step and then the emit step, which loads the
//   result register; an add repeats its step, the day stepper advancing one
//   day a cycle, until the count is spent or the date reaches 31 Dec 2100.
//   A new command is accepted only after the previous result has been
//   loaded into the output register.
// - The result sits in an output register. A stalled receiver holds it
//   there while the next command is taken and worked; that command's result
//   waits for the register to drain before it is loaded.
// - Reset sets the date to 1 Jan 1900 and empties the output register.
// ----------------------------------------------------------------------------
module calendar_date_counter_core #(
    parameter int ADD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdc_in_if.sink    i_in,
    cdc_out_if.source o_out
);

    cdc_pkg::t_uword w_uword;
    cdc_pkg::t_flags w_flags;

    // The input is ready only on the fetch step.
    assign i_in.ready = (w_uword.op == cdc_pkg::OP_ACCEPT);

    // Step counter and control program.
    cdc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .i_mode  (i_in.mode),
        .o_uword (w_uword)
    );

    // Date datapath and output register.
    cdc_dp #(
        .ADD_BITS (ADD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .i_in_valid  (i_in.valid),
        .i_new_day   (i_in.new_day),
        .i_new_month (i_in.new_month),
        .i_new_year  (i_in.new_year),
        .i_add_count (i_in.add_count),
        .i_out_ready (o_out.ready),
        .o_flags     (w_flags),
        .o_out_valid (o_out.valid),
        .o_out_day   (o_out.out_day),
        .o_out_month (o_out.out_month),
        .o_out_year  (o_out.out_year),
        .o_status    (o_out.status)
    );

endmodule

// ----- sv/cdc_checker.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter checker
// Port-level assertions on the date counter core, attached by bind.
// ----------------------------------------------------------------------------
module cdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_out_day,
    input logic [3:0]  i_out_month,
    input logic [11:0] i_out_year,
    input logic [2:0]  i_status
);

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_day) && $stable(i_out_month)
            && $stable(i_out_year) && $stable(i_status))
        else $error("result beat changed while stalled");

    // Commands are worked one at a time: no accept right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while the previous one is in work");

    // Every reported date lies in the supported calendar range.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_month >= 4'd1) && (i_out_month <= 4'd12)
            && (i_out_day >= 5'd1) && (i_out_year >= 12'd1900)
            && (i_out_year <= 12'd2100))
        else $error("reported date out of range");

    // Overflow only ever shows the last day of the range.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == cdc_pkg::ST_OVERFLOW) |->
            (i_out_year == 12'd2100) && (i_out_month == 4'd12) && (i_out_day == 5'd31))
        else $error("overflow reported away from the last day");

endmodule

bind calendar_date_counter_core cdc_checker u_cdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_day   (o_out.out_day),
    .i_out_month (o_out.out_month),
    .i_out_year  (o_out.out_year),
    .i_status    (o_out.status)
);

// ----- tb/calendar_date_checker.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter checker
// Watches the command and result channels, keeps a private copy of the
// date, predicts the result of every accepted command beat and compares
// each accepted result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module calendar_date_checker
    import cdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cdc_in_if    i_cmd,
    cdc_out_if   i_res,
    output int   o_error_count,
    output int   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        t_status     status;
    } t_date_result;

    // Predicted date, kept in plain integers.
    int cal_day   = 1;
    int cal_month = 1;
    int cal_year  = int'(YEAR_BASE);

    t_date_result expected_dates[$];
    int           mismatches = 0;

    // Gregorian leap rule over the full year number.
    function automatic bit leap_year(input int year);
        return (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
    endfunction

    function automatic int month_length(input int month, input int year);
        case (month)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(year) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Moves the date one day on; refuses at the last day of the range.
    function automatic bit step_one_day();
        if (cal_year >= YEAR_TOP && cal_month == MONTH_TOP && cal_day >= DAY_TOP) begin
            return 1'b0;
        end
        if (cal_day < month_length(cal_month, cal_year)) begin
            cal_day++;
        end else if (cal_month < MONTH_TOP) begin
            cal_month++;
            cal_day = 1;
        end else begin
            cal_year++;
            cal_month = 1;
            cal_day   = 1;
        end
        return 1'b1;
    endfunction

    // Applies one command to the predicted date and returns its status.
    function automatic t_status apply_command(input t_mode mode, input int day,
                                              input int month, input int year,
                                              input int count);
        t_status status;
        status = ST_OK;
        case (mode)
            MODE_SET: begin
                if (month < 1 || month > MONTH_TOP) begin
                    status = ST_BAD_MONTH;
                end else if (year < YEAR_BASE || year > YEAR_TOP) begin
                    status = ST_BAD_YEAR;
                end else if (day < 1 || day > month_length(month, year)) begin
                    status = ST_BAD_DAY;
                end else begin
                    cal_day   = day;
                    cal_month = month;
                    cal_year  = year;
                end
            end
            MODE_INC: begin
                if (!step_one_day()) begin
                    status = ST_OVERFLOW;
                end
            end
            MODE_ADD: begin
                for (int i = 0; i < count; i++) begin
                    if (!step_one_day()) begin
                        status = ST_OVERFLOW;
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        return status;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result beats are checked before the command beat of the same edge is
    // predicted; a command never returns its result on its accepting edge.
    always @(posedge i_clk) begin
        t_date_result want;
        t_date_result got;
        if (!i_rst_n) begin
            cal_day   = 1;
            cal_month = 1;
            cal_year  = int'(YEAR_BASE);
            expected_dates.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.day    = i_res.out_day;
                got.month  = i_res.out_month;
                got.year   = i_res.out_year;
                got.status = i_res.status;
                if (expected_dates.size() == 0) begin
                    $display({"%0t ns: unexpected result beat: expected none, ",
                              "actual %0d/%0d/%0d status %0d"},
                             $time, got.day, got.month, got.year, got.status);
                    mismatches++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("day", int'(want.day), int'(got.day));
                    check_field("month", int'(want.month), int'(got.month));
                    check_field("year", int'(want.year), int'(got.year));
                    check_field("status", int'(want.status), int'(got.status));
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                want.status = apply_command(i_cmd.mode, int'(i_cmd.new_day),
                                            int'(i_cmd.new_month), int'(i_cmd.new_year),
                                            int'(i_cmd.add_count));
                want.day    = cal_day[4:0];
                want.month  = cal_month[3:0];
                want.year   = cal_year[11:0];
                expected_dates.push_back(want);
            end
        end
        o_error_count   <= mismatches;
        o_pending_count <= expected_dates.size();
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Calendar date counter testbench
// Drives directed and random command beats into the date counter with
// random idling on both channels, a long receiver hold-off and a full
// drain pause, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
    import cdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_mode MODE_UNUSED  = 2'd3;
    localparam int    QUIET_LIMIT  = 200000;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    PHASE_ITEMS  = 600;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdc_in_if  cmd_ch ();
    cdc_out_if res_ch ();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int items_sent;
    int quiet_cycles = 0;
    int error_count;
    int pending_count;

    calendar_date_counter_core #(
        .ADD_BITS(16)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    calendar_date_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_ch),
        .i_res          (res_ch),
        .o_error_count  (error_count),
        .o_pending_count(pending_count)
    );

    // Clock generation.
    always #1 i_clk = ~i_clk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        res_ch.ready = 1'b0;
        hold_served  = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready = 1'b0;
            end else begin
                res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one command beat, with random idle cycles ahead of it, and
    // returns on the falling edge after it has been taken.
    task automatic send_cmd(input t_mode mode, input logic [4:0] day,
                            input logic [3:0] month, input logic [11:0] year,
                            input logic [15:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.mode      = mode;
        cmd_ch.new_day   = day;
        cmd_ch.new_month = month;
        cmd_ch.new_year  = year;
        cmd_ch.add_count = count;
        cmd_ch.valid     = 1'b1;
        @(posedge i_clk);
        while (!cmd_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        items_sent++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain_results();
        cmd_ch.valid = 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    // One forward step with junk in the fields the mode ignores.
    task automatic walk_step(input int max_count);
        if ($urandom_range(1)) begin
            send_cmd(MODE_INC, 5'($urandom), 4'($urandom), 12'($urandom), 16'($urandom));
        end else begin
            send_cmd(MODE_ADD, 5'($urandom), 4'($urandom), 12'($urandom),
                     16'($urandom_range(0, max_count)));
        end
    endtask

    // Random sequences: most often a valid set followed by forward steps, else
    // month-end probes, top saturation, malformed sets or stray mode 1-3 beats.
    task automatic run_random(input int target);
        int kind;
        int year;
        target += items_sent;
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                send_cmd(MODE_SET, 5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)),
                         12'($urandom_range(YEAR_BASE, YEAR_TOP)), 16'($urandom));
                repeat ($urandom_range(1, 6)) walk_step(60);
            end else if (kind < 55) begin
                // Month ends, with the century years weighted up.
                case ($urandom_range(3))
                    0:       year = 1900;
                    1:       year = 2000;
                    2:       year = YEAR_TOP;
                    default: year = $urandom_range(YEAR_BASE, YEAR_TOP);
                endcase
                send_cmd(MODE_SET, 5'($urandom_range(28, 31)), 4'($urandom_range(1, 12)),
                         12'(year), 16'($urandom));
                repeat ($urandom_range(1, 3)) walk_step(2);
            end else if (kind < 70) begin
                // Close to the top of the range any count saturates quickly.
                send_cmd(MODE_SET, 5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)),
                         12'($urandom_range(YEAR_TOP - 1, YEAR_TOP)), 16'($urandom));
                repeat ($urandom_range(1, 3)) walk_step(65535);
            end else if (kind < 90) begin
                if ($urandom_range(1)) begin
                    year = $urandom_range(0, 4095);
                end else begin
                    year = $urandom_range(YEAR_BASE - 2, YEAR_TOP + 2);
                end
                send_cmd(MODE_SET, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                         12'(year), 16'($urandom));
            end else begin
                send_cmd(t_mode'($urandom_range(1, 3)), 5'($urandom), 4'($urandom),
                         12'($urandom), 16'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.mode      = MODE_SET;
        cmd_ch.new_day   = '0;
        cmd_ch.new_month = '0;
        cmd_ch.new_year  = '0;
        cmd_ch.add_count = '0;
        send_idle_pct    = 17;
        recv_idle_pct    = 65;
        hold_requests    = 0;
        items_sent       = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: steps from the reset date, field checks in their order,
        // leap days, month and year ends, and saturation at the top.
        send_cmd(MODE_INC, 5'd31, 4'd15, 12'd4095, 16'hffff);
        send_cmd(MODE_ADD, 5'd31, 4'd15, 12'd4095, 16'd0);
        send_cmd(MODE_UNUSED, 5'd31, 4'd15, 12'd4095, 16'hffff);
        send_cmd(MODE_SET, 5'd1, 4'd0, 12'd2000, 16'd0);
        send_cmd(MODE_SET, 5'd1, 4'd13, 12'd2000, 16'd0);
        send_cmd(MODE_SET, 5'd31, 4'd15, 12'd4095, 16'hffff);
        send_cmd(MODE_SET, 5'd1, 4'd1, 12'd1899, 16'd0);
        send_cmd(MODE_SET, 5'd0, 4'd1, 12'd2101, 16'd0);
        send_cmd(MODE_SET, 5'd1, 4'd12, 12'd4095, 16'd0);
        send_cmd(MODE_SET, 5'd0, 4'd5, 12'd2000, 16'd0);
        send_cmd(MODE_SET, 5'd31, 4'd4, 12'd2000, 16'd0);
        send_cmd(MODE_SET, 5'd29, MONTH_FEB, 12'd1900, 16'd0);
        send_cmd(MODE_SET, 5'd29, MONTH_FEB, YEAR_TOP, 16'd0);
        send_cmd(MODE_SET, 5'd29, MONTH_FEB, 12'd2000, 16'd0);
        send_cmd(MODE_INC, 5'd0, 4'd0, 12'd0, 16'd0);
        send_cmd(MODE_SET, 5'd28, MONTH_FEB, 12'd2096, 16'd0);
        send_cmd(MODE_INC, 5'd0, 4'd0, 12'd0, 16'd0);
        send_cmd(MODE_SET, 5'd31, 4'd12, 12'd1999, 16'd0);
        send_cmd(MODE_INC, 5'd0, 4'd0, 12'd0, 16'd0);
        send_cmd(MODE_SET, 5'd30, 4'd12, YEAR_TOP, 16'd0);
        send_cmd(MODE_ADD, 5'd0, 4'd0, 12'd0, 16'd1);
        send_cmd(MODE_INC, 5'd0, 4'd0, 12'd0, 16'd0);
        send_cmd(MODE_ADD, 5'd0, 4'd0, 12'd0, 16'd0);
        send_cmd(MODE_SET, 5'd25, 4'd12, YEAR_TOP, 16'd0);
        send_cmd(MODE_ADD, 5'd0, 4'd0, 12'd0, 16'hffff);
        send_cmd(MODE_SET, 5'd1, 4'd1, YEAR_BASE, 16'd0);
        send_cmd(MODE_ADD, 5'd0, 4'd0, 12'd0, 16'hffff);

        // Sender lightly idle, receiver mostly stalled, with one long hold-off
        // while beats keep coming so the block backs up into its input.
        run_random(PHASE_ITEMS / 3);
        hold_requests++;
        run_random(PHASE_ITEMS / 3);
        run_random(PHASE_ITEMS / 3);
        drain_results();

        // Roles swapped, with a full pause halfway.
        send_idle_pct = 65;
        recv_idle_pct = 17;
        run_random(PHASE_ITEMS / 2);
        drain_results();
        run_random(PHASE_ITEMS / 2);
        drain_results();

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        drain_results();

        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- calendar_date_counter_core.f -----
sv/cdc_pkg.sv
sv/cdc_if.sv
sv/cdc_seq.sv
sv/cdc_dp.sv
sv/calendar_date_counter_core.sv
sv/cdc_checker.sv
tb/calendar_date_checker.sv
tb/testbench.sv
